@@ src/dtss_pkg.sv @@
package dtss_pkg;

    // Coverage level of the solid core
    localparam logic [4:0] FULL_LEVEL = 5'd16;

    // Configuration register indexes
    localparam logic [2:0] CFG_SINE   = 3'd0;
    localparam logic [2:0] CFG_COSINE = 3'd1;
    localparam logic [2:0] CFG_START  = 3'd2;
    localparam logic [2:0] CFG_END    = 3'd3;
    localparam logic [2:0] CFG_HALF   = 3'd4;
    localparam logic [2:0] CFG_CORE   = 3'd5;

    // Grain hash: only the low HASH_BITS bits of the product sum reach the test
    localparam int unsigned HASH_SHIFT  = 13;
    localparam int unsigned HASH_BITS   = HASH_SHIFT + 8;
    localparam logic [31:0] HASH_MUL_X  = 32'd1664525;
    localparam logic [31:0] HASH_MUL_Y  = 32'd22695477;
    localparam logic [7:0]  HASH_MASK   = 8'hFF;
    localparam logic [7:0]  LIGHT_LIMIT = 8'd8;

    // 4x4 ordered dither thresholds, indexed [y][x]
    localparam logic [3:0] DITHER_MATRIX [4][4] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6},
        '{4'd3,  4'd11, 4'd1,  4'd9},
        '{4'd15, 4'd7,  4'd13, 4'd5}
    };

    // Input word
    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
    } t_pixel;

    // Result word
    typedef struct packed {
        logic paint;
        logic light_grain;
    } t_result;

    // Segment configuration
    typedef struct packed {
        logic signed [17:0] sine_q16;
        logic signed [17:0] cosine_q16;
        logic signed [8:0]  start_radius;
        logic signed [8:0]  end_radius;
        logic [5:0]         half_width;
        logic [5:0]         core_half_width;
    } t_cfg;

    // Geometry results handed to the coverage stages
    typedef struct packed {
        logic       hit;
        logic [5:0] aperp;
        logic [8:0] dtail;
        logic [8:0] dtip;
        logic [1:0] dx2;
        logic [1:0] dy2;
    } t_geom;

endpackage

@@ src/dithered_thick_segment_shader.sv @@
// Channel   Direction  Handshake                  Word
// --------  ---------  -------------------------  ---------------------------------
// pixel     in         start & !busy              i_pixel   (pixel_x, pixel_y)
// result    out        o_strobe, one cycle        o_result  (paint, light_grain)
// config    in         i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel word is taken every cycle; busy is never raised.
// Each result passes through three geometry stages
// (products, projections, range tests), then side ramp divider and level/dither.
// The result receiver cannot stall, so the pipeline always advances.
// Reset clears the valid bits and loads the default configuration.
// Config is always ready; a write to an index past the list is dropped.
module dithered_thick_segment_shader
    import dtss_pkg::*;
#(
    parameter int DISPLAY_WIDTH   = 144,
    parameter int DISPLAY_HEIGHT  = 168,
    parameter int END_FADE_LENGTH = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_pixel      i_pixel,
    output logic        o_strobe,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [17:0] i_cfg_data
);

    // Configuration registers
    t_cfg r_cfg, n_cfg;
    logic w_cfg_write;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_cfg_write) begin
            unique case (i_cfg_index)
                CFG_SINE:   n_cfg.sine_q16        = i_cfg_data;
                CFG_COSINE: n_cfg.cosine_q16      = i_cfg_data;
                CFG_START:  n_cfg.start_radius    = i_cfg_data[8:0];
                CFG_END:    n_cfg.end_radius      = i_cfg_data[8:0];
                CFG_HALF:   n_cfg.half_width      = i_cfg_data[5:0];
                CFG_CORE:   n_cfg.core_half_width = i_cfg_data[5:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sine_q16        <= 18'sd0;
            r_cfg.cosine_q16      <= 18'sd65536;
            r_cfg.start_radius    <= 9'sd0;
            r_cfg.end_radius      <= 9'sd0;
            r_cfg.half_width      <= 6'd0;
            r_cfg.core_half_width <= 6'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Pixel intake
    logic w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Geometry stages
    logic  w_geom_valid;
    t_geom w_geom;

    dtss_geom #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_pixel (i_pixel),
        .i_cfg   (r_cfg),
        .o_valid (w_geom_valid),
        .o_geom  (w_geom)
    );

    // Coverage level and dither
    logic w_paint;

    dtss_ramp #(
        .END_FADE_LENGTH (END_FADE_LENGTH)
    ) u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_geom_valid),
        .i_geom  (w_geom),
        .i_cfg   (r_cfg),
        .o_valid (o_strobe),
        .o_paint (w_paint)
    );

    // Grain color, aligned with the coverage path
    logic w_light;

    dtss_grain u_grain (
        .i_clk   (i_clk),
        .i_pixel (i_pixel),
        .o_light (w_light)
    );

    assign o_result.paint       = w_paint;
    assign o_result.light_grain = w_paint && w_light;

    // Every accepted pixel yields a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##5 o_strobe)
        else $error("result strobe missing five cycles after accept");

    // A result is always backed by an earlier geometry word
    a_stage_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_geom_valid, 2))
        else $error("result strobe without geometry word");

    // Writes past the register list leave the configuration alone
    a_cfg_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_write && (i_cfg_index > CFG_CORE)) |=> $stable(r_cfg))
        else $error("config changed by out-of-range write");

endmodule

@@ src/dtss_geom.sv @@
module dtss_geom
    import dtss_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 144,
    parameter int DISPLAY_HEIGHT = 168
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_pixel i_pixel,
    input  t_cfg   i_cfg,
    output logic   o_valid,
    output t_geom  o_geom
);

    localparam logic signed [9:0] CENTER_X = 10'(DISPLAY_WIDTH / 2);
    localparam logic signed [9:0] CENTER_Y = 10'(DISPLAY_HEIGHT / 2);
    localparam logic [8:0]        LIMIT_X  = 9'(DISPLAY_WIDTH);
    localparam logic [8:0]        LIMIT_Y  = 9'(DISPLAY_HEIGHT);

    // Stage 1: offsets from the center and the four products
    logic signed [9:0]  w_dx, w_dy;
    logic signed [27:0] n1_dxs, n1_dyc, n1_dxc, n1_dys;
    logic               n1_on;

    assign w_dx   = signed'({2'b00, i_pixel.pixel_x}) - CENTER_X;
    assign w_dy   = signed'({2'b00, i_pixel.pixel_y}) - CENTER_Y;
    assign n1_dxs = w_dx * $signed(i_cfg.sine_q16);
    assign n1_dyc = w_dy * $signed(i_cfg.cosine_q16);
    assign n1_dxc = w_dx * $signed(i_cfg.cosine_q16);
    assign n1_dys = w_dy * $signed(i_cfg.sine_q16);
    assign n1_on  = ({1'b0, i_pixel.pixel_x} < LIMIT_X) && ({1'b0, i_pixel.pixel_y} < LIMIT_Y);

    logic               r1_valid;
    logic signed [27:0] r1_dxs, r1_dyc, r1_dxc, r1_dys;
    logic               r1_on;
    logic [1:0]         r1_dx2, r1_dy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_dxs <= n1_dxs;
        r1_dyc <= n1_dyc;
        r1_dxc <= n1_dxc;
        r1_dys <= n1_dys;
        r1_on  <= n1_on;
        r1_dx2 <= i_pixel.pixel_x[1:0];
        r1_dy2 <= i_pixel.pixel_y[1:0];
    end

    // Stage 2: projections along and across the segment
    logic               r2_valid;
    logic signed [27:0] r2_along, r2_perp;
    logic               r2_on;
    logic [1:0]         r2_dx2, r2_dy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_along <= r1_dxs - r1_dyc;
        r2_perp  <= r1_dxc + r1_dys;
        r2_on    <= r1_on;
        r2_dx2   <= r1_dx2;
        r2_dy2   <= r1_dy2;
    end

    // Stage 3: range and width tests, distances to both ends
    logic signed [27:0] w_r0, w_r1, w_tail_diff, w_tip_diff;
    logic [27:0]        w_perp_abs;
    logic               w_in_range, w_width_ok;
    t_geom              n3_geom;

    assign w_r0        = {{3{i_cfg.start_radius[8]}}, i_cfg.start_radius, 16'b0};
    assign w_r1        = {{3{i_cfg.end_radius[8]}}, i_cfg.end_radius, 16'b0};
    assign w_tail_diff = r2_along - w_r0;
    assign w_tip_diff  = w_r1 - r2_along;
    assign w_perp_abs  = r2_perp[27] ? 28'(-r2_perp) : 28'(r2_perp);
    assign w_in_range  = (r2_along >= w_r0) && (r2_along <= w_r1);
    assign w_width_ok  = w_perp_abs[26:16] <= {5'b0, i_cfg.half_width};

    always_comb begin
        n3_geom.hit   = r2_on && w_in_range && w_width_ok;
        n3_geom.aperp = w_perp_abs[21:16];
        n3_geom.dtail = w_tail_diff[24:16];
        n3_geom.dtip  = w_tip_diff[24:16];
        n3_geom.dx2   = r2_dx2;
        n3_geom.dy2   = r2_dy2;
    end

    logic  r3_valid;
    t_geom r3_geom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_geom <= n3_geom;
    end

    assign o_valid = r3_valid;
    assign o_geom  = r3_geom;

endmodule

@@ src/dtss_ramp.sv @@
module dtss_ramp
    import dtss_pkg::*;
#(
    parameter int END_FADE_LENGTH = 3
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_geom i_geom,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    output logic  o_paint
);

    localparam logic [8:0] FADE_LEN = 9'(END_FADE_LENGTH);

    // End fade levels, one per distance from the end
    logic [4:0] w_fade [16];

    for (genvar gi = 0; gi < 16; gi++) begin : g_fade
        assign w_fade[gi] = 5'((gi * FULL_LEVEL) / END_FADE_LENGTH);
    end

    // Stage 4: side ramp by a short restoring division, end fade by table
    logic [5:0] w_a, w_side;
    logic       w_side_on, w_end_on;
    logic [8:0] w_dend;
    logic [3:0] w_q;
    logic [4:0] n4_t_side, n4_t_end;

    assign w_a       = i_geom.aperp - i_cfg.core_half_width;
    assign w_side    = i_cfg.half_width - i_cfg.core_half_width;
    assign w_side_on = (i_geom.aperp > i_cfg.core_half_width)
                       && (i_cfg.half_width > i_cfg.core_half_width);
    assign w_dend    = (i_geom.dtail < i_geom.dtip) ? i_geom.dtail : i_geom.dtip;
    assign w_end_on  = w_dend < FADE_LEN;

    // q = floor(16 * a / side) for a < side, four quotient bits
    always_comb begin
        logic [6:0] rem;
        rem = {1'b0, w_a};
        w_q = '0;
        for (int i = 3; i >= 0; i--) begin
            rem = {rem[5:0], 1'b0};
            if (rem >= {1'b0, w_side}) begin
                w_q[i] = 1'b1;
                rem    = rem - {1'b0, w_side};
            end
        end
    end

    always_comb begin
        if (!w_side_on) begin
            n4_t_side = FULL_LEVEL;
        end else if (w_a == w_side) begin
            n4_t_side = 5'd0;
        end else begin
            n4_t_side = FULL_LEVEL - {1'b0, w_q};
        end
        n4_t_end = w_end_on ? w_fade[w_dend[3:0]] : FULL_LEVEL;
    end

    logic       r4_valid, r4_hit;
    logic [4:0] r4_t_side, r4_t_end;
    logic [1:0] r4_dx2, r4_dy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= i_valid;
        end
        r4_hit    <= i_geom.hit;
        r4_t_side <= n4_t_side;
        r4_t_end  <= n4_t_end;
        r4_dx2    <= i_geom.dx2;
        r4_dy2    <= i_geom.dy2;
    end

    // Stage 5: final level against the dither threshold
    logic [4:0] w_level;
    logic       n5_paint;

    assign w_level  = (r4_t_side < r4_t_end) ? r4_t_side : r4_t_end;
    assign n5_paint = r4_hit && (w_level != 5'd0)
                      && ((w_level == FULL_LEVEL)
                          || ({1'b0, DITHER_MATRIX[r4_dy2][r4_dx2]} < w_level));

    logic r5_valid, r5_paint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_paint <= n5_paint;
    end

    assign o_valid = r5_valid;
    assign o_paint = r5_paint;

endmodule

@@ src/dtss_grain.sv @@
module dtss_grain
    import dtss_pkg::*;
(
    input  logic   i_clk,
    input  t_pixel i_pixel,
    output logic   o_light
);

    // Stage 1: constant products, low bits only
    logic [HASH_BITS-1:0] r1_px, r1_py;

    always_ff @(posedge i_clk) begin
        r1_px <= HASH_BITS'(HASH_BITS'(i_pixel.pixel_x) * HASH_MUL_X[HASH_BITS-1:0]);
        r1_py <= HASH_BITS'(HASH_BITS'(i_pixel.pixel_y) * HASH_MUL_Y[HASH_BITS-1:0]);
    end

    // Stage 2: hash sum
    logic [HASH_BITS-1:0] r2_h;

    always_ff @(posedge i_clk) begin
        r2_h <= r1_px + r1_py;
    end

    // Stage 3: xor-shift mix and light test
    logic [7:0] w_mix;
    logic       r3_light;

    assign w_mix = (r2_h[7:0] ^ r2_h[HASH_BITS-1:HASH_SHIFT]) & HASH_MASK;

    always_ff @(posedge i_clk) begin
        r3_light <= w_mix < LIGHT_LIMIT;
    end

    // Stages 4 and 5: align with the coverage path
    logic r4_light, r5_light;

    always_ff @(posedge i_clk) begin
        r4_light <= r3_light;
        r5_light <= r4_light;
    end

    assign o_light = r5_light;

endmodule
